[rtl/core/dsm_pkg.sv]
// Package for the direction sample mapper: fixed-point constants, item types,
// the CORDIC angle table and the shared square-root and output rounding steps.
// No dependencies.
package dsm_pkg;

  // Internal fixed-point format is Q.30
  localparam int IFRAC = 30;
  localparam logic signed [63:0] IONE = 64'sd1 <<< IFRAC;
  localparam int CORDIC_STEPS = 30;
  localparam int SQRT_STEPS = 31;
  localparam logic [31:0] CORDIC_GAIN_INV = 32'd652032874;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [36:0] OUT_MAX = 37'sd8388607;
  localparam logic signed [36:0] OUT_MIN = -37'sd8388608;

  // Defaults for the top-level parameters
  localparam int DEF_RANDOM_BITS = 24;
  localparam int DEF_OUT_FRAC_BITS = 22;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  // Register codes of the sample_mode register
  localparam logic [2:0] MODE_DISK = 3'd0;
  localparam logic [2:0] MODE_UHEM = 3'd1;
  localparam logic [2:0] MODE_UCAP = 3'd2;
  localparam logic [2:0] MODE_CCAP = 3'd3;
  localparam logic [2:0] MODE_CHEM = 3'd4;

  // Configuration register index
  typedef enum logic [0:0] {
    CFG_SAMPLE_MODE = 1'b0,
    CFG_CAP_COS_MAX = 1'b1
  } cfg_idx_e;

  // Mapping an item takes after decode
  typedef enum logic [2:0] {
    KIND_DISK,
    KIND_UHEM,
    KIND_UCAP,
    KIND_CCAP,
    KIND_CHEM,
    KIND_ZERO
  } kind_e;

  typedef struct packed {
    logic [23:0] u_frac;
    logic [23:0] v_frac;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] dir_x;
    logic signed [23:0] dir_y;
    logic signed [23:0] dir_z;
  } out_item_t;

  // Classified item handed from front to back
  typedef struct packed {
    kind_e              kind;
    logic [29:0]        u;
    logic [31:0]        turn;
    logic signed [31:0] c;
  } cls_t;

  // Remainder and partial root of the bitwise square root
  typedef struct packed {
    logic [61:0] n;
    logic [61:0] res;
  } sq_t;

  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
    32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
    32'd1048575, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
    32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
    32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
    32'd32, 32'd16, 32'd8, 32'd4, 32'd2
  };

  // One root bit: bit weight is 4^k
  function automatic sq_t sqrt_step(sq_t s, int k);
    sq_t         o;
    logic [61:0] b;
    logic [61:0] t;
    b = 62'd1 << (2 * k);
    t = s.res + b;
    if (s.n >= t) begin
      o.n   = s.n - t;
      o.res = (s.res >> 1) + b;
    end else begin
      o.n   = s.n;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // Round half up from Q.30 by sh bits, then saturate to 24 bits
  function automatic logic signed [23:0] round_sat(logic signed [35:0] v, int sh);
    logic signed [36:0] w;
    w = 37'(v);
    if (sh > 0) begin
      w = (w + (37'sd1 <<< (sh - 1))) >>> sh;
    end
    if (w > OUT_MAX) begin
      w = OUT_MAX;
    end
    if (w < OUT_MIN) begin
      w = OUT_MIN;
    end
    return w[23:0];
  endfunction

endpackage

[rtl/core/dsm_front.sv]
// Front of the direction sample mapper: configuration registers, input
// register and item classification. Depends on dsm_pkg.
module dsm_front #(
  parameter int RANDOM_BITS = dsm_pkg::DEF_RANDOM_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  dsm_pkg::cfg_idx_e   cfg_idx_i,
  input  logic [23:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dsm_pkg::in_item_t   in_item_i,
  output logic                push_o,
  output dsm_pkg::cls_t       push_data_o,
  input  logic                full_i
);

  localparam int UW    = (RANDOM_BITS < 24) ? RANDOM_BITS : 24;
  localparam int USH_L = (RANDOM_BITS < dsm_pkg::IFRAC) ? dsm_pkg::IFRAC - RANDOM_BITS : 0;
  localparam int USH_R = (RANDOM_BITS > dsm_pkg::IFRAC) ? RANDOM_BITS - dsm_pkg::IFRAC : 0;
  localparam int VSH   = 32 - RANDOM_BITS;

  logic [2:0]         mode_q;
  logic signed [23:0] cap_q;
  logic               f_v_q;
  dsm_pkg::cls_t      f_q;
  dsm_pkg::cls_t      cls_d;
  logic               f_ready;
  logic [63:0]        u_ext;
  logic [63:0]        v_ext;
  logic signed [31:0] c_wide;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dsm_pkg::MODE_DISK;
      cap_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dsm_pkg::CFG_SAMPLE_MODE: mode_q <= cfg_wdata_i[2:0];
        dsm_pkg::CFG_CAP_COS_MAX: cap_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Align fractions, clamp cap cosine, decode mode
  always_comb begin
    u_ext = 64'(in_item_i.u_frac[UW-1:0]);
    v_ext = 64'(in_item_i.v_frac[UW-1:0]);
    cls_d.u    = 30'((u_ext << USH_L) >> USH_R);
    cls_d.turn = 32'(v_ext << VSH);
    c_wide = 32'(cap_q) <<< 8;
    if (c_wide > 32'(dsm_pkg::IONE)) begin
      cls_d.c = 32'(dsm_pkg::IONE);
    end else if (c_wide < -32'(dsm_pkg::IONE)) begin
      cls_d.c = -32'(dsm_pkg::IONE);
    end else begin
      cls_d.c = c_wide;
    end
    unique case (mode_q)
      dsm_pkg::MODE_DISK: cls_d.kind = dsm_pkg::KIND_DISK;
      dsm_pkg::MODE_UHEM: cls_d.kind = dsm_pkg::KIND_UHEM;
      dsm_pkg::MODE_UCAP: cls_d.kind = dsm_pkg::KIND_UCAP;
      dsm_pkg::MODE_CCAP: cls_d.kind = dsm_pkg::KIND_CCAP;
      dsm_pkg::MODE_CHEM: cls_d.kind = dsm_pkg::KIND_CHEM;
      default:            cls_d.kind = dsm_pkg::KIND_ZERO;
    endcase
  end

  // Hold the item until the queue takes it
  assign f_ready    = !f_v_q || !full_i;
  assign in_stall_o = !f_ready;
  assign push_o     = f_v_q && !full_i;
  assign push_data_o = f_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (f_ready) begin
      f_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && in_valid_i) begin
      f_q <= cls_d;
    end
  end

endmodule

[rtl/core/dsm_queue.sv]
// Short queue of classified items between front and back.
// Depends on dsm_pkg.
module dsm_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dsm_pkg::cls_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output dsm_pkg::cls_t pop_data_o
);

  localparam int PW = $clog2(dsm_pkg::Q_DEPTH);

  dsm_pkg::cls_t mem_q [dsm_pkg::Q_DEPTH];
  logic [PW-1:0] wp_q;
  logic [PW-1:0] rp_q;
  logic [PW:0]   cnt_q;
  logic          do_push;
  logic          do_pop;

  assign full_o     = (cnt_q == (PW+1)'(dsm_pkg::Q_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rp_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (do_pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end

endmodule

[rtl/core/dsm_sqrt.sv]
// Pipelined bitwise square root: floor(sqrt(arg * 2^30)), one root bit per
// stage. Depends on dsm_pkg.
module dsm_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] arg_i,
  output logic [30:0] root_o
);

  localparam int N = dsm_pkg::SQRT_STEPS;

  dsm_pkg::sq_t st_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    dsm_pkg::sq_t st_in;
    if (s == 0) begin : g_first
      assign st_in = '{n: 62'(arg_i) << dsm_pkg::IFRAC, res: '0};
    end else begin : g_next
      assign st_in = st_q[s-1];
    end
    // Resolve the root bit of weight 4^(N-1-s)
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[s] <= dsm_pkg::sqrt_step(st_in, N - 1 - s);
      end
    end
  end

  assign root_o = st_q[N-1].res[30:0];

endmodule

[rtl/core/dsm_cordic.sv]
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, giving cos
// and sin of a first-quadrant angle in Q.30. Depends on dsm_pkg.
module dsm_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [30:0]        ang_i,
  input  logic [1:0]         quad_i,
  output logic signed [32:0] x_o,
  output logic signed [32:0] y_o,
  output logic [1:0]         quad_o
);

  localparam int N = dsm_pkg::CORDIC_STEPS;

  logic signed [32:0] x_q [N];
  logic signed [32:0] y_q [N];
  logic signed [32:0] z_q [N];
  logic [1:0]         q_q [N];

  for (genvar i = 0; i < N; i++) begin : g_step
    logic signed [32:0] xi;
    logic signed [32:0] yi;
    logic signed [32:0] zi;
    logic [1:0]         qi;
    logic signed [32:0] at;
    if (i == 0) begin : g_first
      assign xi = 33'(dsm_pkg::CORDIC_GAIN_INV);
      assign yi = '0;
      assign zi = $signed({2'b00, ang_i});
      assign qi = quad_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign qi = q_q[i-1];
    end
    assign at = $signed({1'b0, dsm_pkg::ATAN_TAB[i]});
    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (zi >= 0) begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - at;
        end else begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + at;
        end
        q_q[i] <= qi;
      end
    end
  end

  assign x_o    = x_q[N-1];
  assign y_o    = y_q[N-1];
  assign quad_o = q_q[N-1];

endmodule

[rtl/core/dsm_back.sv]
// Back of the direction sample mapper: product stages, three root units,
// CORDIC, final products, rounding and the output register.
// Depends on dsm_pkg, dsm_sqrt and dsm_cordic.
module dsm_back #(
  parameter int OUT_FRAC_BITS = dsm_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  dsm_pkg::cls_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dsm_pkg::out_item_t out_item_o
);

  localparam int NV  = 4 + dsm_pkg::SQRT_STEPS + 2;
  localparam int KD  = dsm_pkg::SQRT_STEPS;
  localparam int CD  = dsm_pkg::SQRT_STEPS + 3 - dsm_pkg::CORDIC_STEPS;
  localparam int SH  = dsm_pkg::IFRAC - OUT_FRAC_BITS;
  localparam logic [30:0] ONE31 = 31'(dsm_pkg::IONE);
  localparam logic signed [32:0] ONE33 = 33'(dsm_pkg::IONE);

  logic en;
  logic v_q [NV];
  logic out_v_q;
  dsm_pkg::out_item_t out_q;

  // Advance everything unless a finished item waits under an output stall
  assign en    = !out_v_q || !out_stall_i;
  assign pop_o = en && q_valid_i;

  // Stage 1: cap products and angle scaling
  logic signed [63:0] cc;
  logic [60:0]        ap;
  dsm_pkg::kind_e     k1_q;
  logic [29:0]        u1_q;
  logic [30:0]        s2_1_q;
  logic [31:0]        t1_q;
  logic [30:0]        ang1_q;
  logic [1:0]         quad1_q;

  assign cc = 64'(q_data_i.c) * 64'(q_data_i.c);
  assign ap = 61'(q_data_i.turn[29:0]) * 61'(dsm_pkg::HALF_PI_Q30);

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q    <= q_data_i.kind;
      u1_q    <= q_data_i.u;
      s2_1_q  <= 31'(dsm_pkg::IONE - (cc >>> dsm_pkg::IFRAC));
      t1_q    <= 32'(dsm_pkg::IONE - 64'(q_data_i.c));
      ang1_q  <= 31'(ap >> dsm_pkg::IFRAC);
      quad1_q <= q_data_i.turn[31:30];
    end
  end

  // Stage 2: u times (1 - c) or times the squared sine
  logic [31:0]    sel2;
  logic [61:0]    pp;
  dsm_pkg::kind_e k2_q;
  logic [29:0]    u2_q;
  logic [30:0]    s2_2_q;
  logic [31:0]    p2_q;

  assign sel2 = (k1_q == dsm_pkg::KIND_CCAP) ? 32'(s2_1_q) : t1_q;
  assign pp   = 62'(u1_q) * 62'(sel2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      k2_q   <= k1_q;
      u2_q   <= u1_q;
      s2_2_q <= s2_1_q;
      p2_q   <= 32'(pp >> dsm_pkg::IFRAC);
    end
  end

  // Stage 3: height and its square
  logic signed [32:0] zsel;
  logic signed [65:0] zzp;
  dsm_pkg::kind_e     k3_q;
  logic [29:0]        u3_q;
  logic [30:0]        s2_3_q;
  logic [31:0]        p3_q;
  logic signed [32:0] z3_q;
  logic [30:0]        zz3_q;

  assign zsel = (k2_q == dsm_pkg::KIND_UHEM) ? $signed({3'b000, u2_q})
                                              : ONE33 - $signed({1'b0, p2_q});
  assign zzp  = 66'(zsel) * 66'(zsel);

  always_ff @(posedge clk_i) begin
    if (en) begin
      k3_q   <= k2_q;
      u3_q   <= u2_q;
      s2_3_q <= s2_2_q;
      p3_q   <= p2_q;
      z3_q   <= zsel;
      zz3_q  <= 31'(zzp >>> dsm_pkg::IFRAC);
    end
  end

  // Stage 4: select root arguments
  logic [30:0]        arg_a;
  logic [30:0]        arg_b;
  dsm_pkg::kind_e     k4_q;
  logic signed [32:0] z4_q;
  logic [30:0]        a4_q;
  logic [30:0]        b4_q;
  logic [30:0]        c4_q;

  always_comb begin
    case (k3_q)
      dsm_pkg::KIND_UHEM, dsm_pkg::KIND_UCAP: arg_a = ONE31 - zz3_q;
      default:                                arg_a = {1'b0, u3_q};
    endcase
    case (k3_q)
      dsm_pkg::KIND_CCAP: arg_b = 31'(ONE33 - $signed({1'b0, p3_q}));
      dsm_pkg::KIND_CHEM: arg_b = ONE31 - {1'b0, u3_q};
      default:            arg_b = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k4_q <= k3_q;
      z4_q <= z3_q;
      a4_q <= arg_a;
      b4_q <= arg_b;
      c4_q <= s2_3_q;
    end
  end

  // Root units and angle unit
  logic [30:0]        root_a;
  logic [30:0]        root_b;
  logic [30:0]        root_c;
  logic signed [32:0] cx;
  logic signed [32:0] cy;
  logic [1:0]         cq;

  dsm_sqrt u_sqrt_a (.clk_i(clk_i), .en_i(en), .arg_i(a4_q), .root_o(root_a));
  dsm_sqrt u_sqrt_b (.clk_i(clk_i), .en_i(en), .arg_i(b4_q), .root_o(root_b));
  dsm_sqrt u_sqrt_c (.clk_i(clk_i), .en_i(en), .arg_i(c4_q), .root_o(root_c));

  dsm_cordic u_cordic (
    .clk_i (clk_i),
    .en_i  (en),
    .ang_i (ang1_q),
    .quad_i(quad1_q),
    .x_o   (cx),
    .y_o   (cy),
    .quad_o(cq)
  );

  // Delay kind and height alongside the roots, cos/sin alongside too
  dsm_pkg::kind_e     kd_q [KD];
  logic signed [32:0] zd_q [KD];
  logic signed [32:0] xd_q [CD];
  logic signed [32:0] yd_q [CD];
  logic [1:0]         qd_q [CD];

  always_ff @(posedge clk_i) begin
    if (en) begin
      kd_q[0] <= k4_q;
      zd_q[0] <= z4_q;
      for (int i = 1; i < KD; i++) begin
        kd_q[i] <= kd_q[i-1];
        zd_q[i] <= zd_q[i-1];
      end
      xd_q[0] <= cx;
      yd_q[0] <= cy;
      qd_q[0] <= cq;
      for (int i = 1; i < CD; i++) begin
        xd_q[i] <= xd_q[i-1];
        yd_q[i] <= yd_q[i-1];
        qd_q[i] <= qd_q[i-1];
      end
    end
  end

  // Stage 36: radial length, quadrant fold, final height
  dsm_pkg::kind_e     kf;
  logic [61:0]        rp;
  logic [30:0]        r_d;
  logic signed [33:0] cs_d;
  logic signed [33:0] sn_d;
  logic signed [32:0] z_d;
  logic signed [33:0] xw;
  logic signed [33:0] yw;
  logic [30:0]        r36_q;
  logic signed [33:0] cs36_q;
  logic signed [33:0] sn36_q;
  logic signed [32:0] z36_q;

  assign kf = kd_q[KD-1];
  assign rp = 62'(root_a) * 62'(root_c);
  assign xw = 34'(xd_q[CD-1]);
  assign yw = 34'(yd_q[CD-1]);

  always_comb begin
    case (qd_q[CD-1])
      2'd0:    begin cs_d = xw;  sn_d = yw;  end
      2'd1:    begin cs_d = -yw; sn_d = xw;  end
      2'd2:    begin cs_d = -xw; sn_d = -yw; end
      default: begin cs_d = yw;  sn_d = -xw; end
    endcase
    case (kf)
      dsm_pkg::KIND_CCAP: r_d = 31'(rp >> dsm_pkg::IFRAC);
      dsm_pkg::KIND_ZERO: r_d = '0;
      default:            r_d = root_a;
    endcase
    case (kf)
      dsm_pkg::KIND_UHEM, dsm_pkg::KIND_UCAP: z_d = zd_q[KD-1];
      dsm_pkg::KIND_CCAP, dsm_pkg::KIND_CHEM: z_d = $signed({2'b00, root_b});
      default:                                z_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r36_q  <= r_d;
      cs36_q <= cs_d;
      sn36_q <= sn_d;
      z36_q  <= z_d;
    end
  end

  // Stage 37: scale cos and sin by the radial length
  logic signed [65:0] pxp;
  logic signed [65:0] pyp;
  logic signed [35:0] px37_q;
  logic signed [35:0] py37_q;
  logic signed [32:0] z37_q;

  assign pxp = 66'($signed({1'b0, r36_q})) * 66'(cs36_q);
  assign pyp = 66'($signed({1'b0, r36_q})) * 66'(sn36_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      px37_q <= 36'(pxp >>> dsm_pkg::IFRAC);
      py37_q <= 36'(pyp >>> dsm_pkg::IFRAC);
      z37_q  <= z36_q;
    end
  end

  // Output register: round and saturate
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.dir_x <= dsm_pkg::round_sat(px37_q, SH);
      out_q.dir_y <= dsm_pkg::round_sat(py37_q, SH);
      out_q.dir_z <= dsm_pkg::round_sat(36'(z37_q), SH);
    end
  end

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NV; i++) begin
        v_q[i] <= 1'b0;
      end
      out_v_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= q_valid_i;
      for (int i = 1; i < NV; i++) begin
        v_q[i] <= v_q[i-1];
      end
      out_v_q <= v_q[NV-1];
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

[rtl/core/direction_sample_mapper_unit.sv]
// Top level of the direction sample mapper: front, queue and back.
// Depends on dsm_pkg, dsm_front, dsm_queue and dsm_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o   | in_item_i (u_frac, v_frac)
//   output   | out_valid_o / out_stall_i | out_item_o (dir_x, dir_y, dir_z)
//   config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled; every stage is
// pipelined. An accepted input passes the front register, one queue slot, four
// product stages, 31 root stages, two final stages and the output register.
// The root units set the depth.
// Reset clears the mode and cap registers to zero and empties the pipeline.
// An output stall with a result waiting freezes the back; the queue then absorbs
// up to four items before the input stalls.
module direction_sample_mapper_unit #(
  parameter int RANDOM_BITS   = dsm_pkg::DEF_RANDOM_BITS,
  parameter int OUT_FRAC_BITS = dsm_pkg::DEF_OUT_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  dsm_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dsm_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dsm_pkg::out_item_t out_item_o
);

  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  dsm_pkg::cls_t push_data;
  dsm_pkg::cls_t pop_data;

  dsm_front #(.RANDOM_BITS(RANDOM_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .push_data_o(push_data),
    .full_i     (full)
  );

  dsm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_data)
  );

  dsm_back #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

[rtl/core/dsm_checker.sv]
// Port-level checks for the direction sample mapper, bound to the top level.
// Depends on dsm_pkg and direction_sample_mapper_unit.
module dsm_port_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input dsm_pkg::out_item_t out_item_o
);

  // No result straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output changed");

  // A moving back end keeps the queue from filling
  a_no_back_pressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |=> !in_stall_o)
    else $error("input stalled although output was not");

endmodule

bind direction_sample_mapper_unit dsm_port_checker u_dsm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
